/* design/bhpq_pkg.sv */
package bhpq_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_TAKE_RD,
        S_TAKE_WR,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } fsm_t;

    // true if score a goes strictly ahead of score b
    function automatic logic ahead(input logic signed [31:0] a,
                                   input logic signed [31:0] b,
                                   input logic mode);
        begin
            ahead = mode ? (a < b) : (a > b);
        end
    endfunction

endpackage

/* design/binary_heap_priority_queue_pairs_top.sv */
// Insert: the item enters at the next free slot and moves up, one UP_RD and UP_CMP per
// level, until it no longer goes ahead of its parent or reaches the root.
// Extract: TAKE_RD and TAKE_WR read the root and the last item, then each slot visited
// runs DN_RD, a read of each child present and DN_CMP; a symmetric follow-up extract may run.
// One item at a time: busy is high from accept through the done strobe, and no new
// item is taken while it is high; the receiver cannot stall. Reset (async, rst_n low)
// empties the heap, clears the pair count and order_mode.
module binary_heap_priority_queue_pairs_top
    import bhpq_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int MOVE_BITS  = 16,
    parameter int INDEX_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic                                kind,
    input  logic [MOVE_BITS-1:0]                move_code,
    input  logic [INDEX_BITS-1:0]               move_ref,
    input  logic signed [31:0]                  score,
    input  logic                                symmetric,
    output logic                                done,
    output logic [1:0]                          status,
    output logic [$clog2(CAPACITY)-1:0]         position,
    output logic [MOVE_BITS-1:0]                out_move,
    output logic [INDEX_BITS-1:0]               out_index,
    output logic signed [31:0]                  out_score,
    output logic                                out_symmetric,
    output logic                                extract_ready,
    output logic [$clog2(CAPACITY + 1)-1:0]     count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic [MOVE_BITS-1:0]  mv;
        logic [INDEX_BITS-1:0] idx;
        logic signed [31:0]    key;
        logic                  sym;
    } entry_t;

    entry_t mem [CAPACITY];
    entry_t rd_q;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    entry_t        mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_q <= mem[mem_ra];
        end
    end

    fsm_t          state_reg, state_next;
    logic          mode_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pair_reg, pair_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] best_reg, best_next;
    entry_t        cur_reg, cur_next;    // item being sifted
    entry_t        bval_reg, bval_next;  // best of the item and its children so far
    entry_t        got_reg, got_next;
    logic          second_reg, second_next;
    logic [1:0]    stat_reg, stat_next;
    logic [AW-1:0] rpos_reg, rpos_next;

    logic [AW:0]   lch, rch;
    logic [AW-1:0] par;

    assign lch = {pos_reg, 1'b1};
    assign rch = lch + 1'b1;
    assign par = (pos_reg - 1'b1) >> 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= 1'b0;
            cnt_reg    <= '0;
            pair_reg   <= '0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pair_reg   <= pair_next;
            second_reg <= second_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        best_reg <= best_next;
        cur_reg  <= cur_next;
        bval_reg <= bval_next;
        got_reg  <= got_next;
        stat_reg <= stat_next;
        rpos_reg <= rpos_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pair_next   = pair_reg;
        pos_next    = pos_reg;
        best_next   = best_reg;
        cur_next    = cur_reg;
        bval_next   = bval_reg;
        got_next    = got_reg;
        second_next = second_reg;
        stat_next   = stat_reg;
        rpos_next   = rpos_reg;
        mem_we = 1'b0;
        mem_wa = pos_reg;
        mem_wd = cur_reg;
        mem_re = 1'b0;
        mem_ra = par;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    stat_next   = ST_OK;
                    rpos_next   = '0;
                    got_next    = '0;
                    second_next = 1'b0;
                    if (kind == KIND_INSERT)
                    begin
                        if (cnt_reg >= CW'(CAPACITY))
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next.mv  = move_code;
                            cur_next.idx = move_ref;
                            cur_next.key = score;
                            cur_next.sym = symmetric;
                            if (symmetric && pair_reg < CW'(CAPACITY))
                            begin
                                pair_next = pair_reg + 1'b1;
                            end
                            pos_next   = cnt_reg[AW-1:0];
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        stat_next  = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_TAKE_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    rpos_next  = pos_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = par;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (ahead(cur_reg.key, rd_q.key, mode_reg))
                begin
                    mem_we     = 1'b1;
                    mem_wd     = rd_q;
                    pos_next   = par;
                    state_next = S_UP_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    rpos_next  = pos_reg;
                    state_next = S_DONE;
                end
            end
            S_TAKE_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = '0;
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                // root captured; fetch last item
                got_next   = rd_q;
                cnt_next   = cnt_reg - 1'b1;
                mem_re     = 1'b1;
                mem_ra     = AW'(cnt_reg - 1'b1);
                pos_next   = '0;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                // at the root the last item has just been read; deeper down cur is held
                if (pos_reg == '0)
                begin
                    cur_next = rd_q;
                end
                if (lch < (AW+1)'(cnt_reg))
                begin
                    mem_re     = 1'b1;
                    mem_ra     = lch[AW-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_DN_CMP;
                    best_next  = pos_reg;
                end
            end
            S_DN_L:
            begin
                if (ahead(rd_q.key, cur_reg.key, mode_reg))
                begin
                    best_next = lch[AW-1:0];
                    bval_next = rd_q;
                end
                else
                begin
                    best_next = pos_reg;
                    bval_next = cur_reg;
                end
                if (rch < (AW+1)'(cnt_reg))
                begin
                    mem_re     = 1'b1;
                    mem_ra     = rch[AW-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_R:
            begin
                if (ahead(rd_q.key, bval_reg.key, mode_reg))
                begin
                    best_next = rch[AW-1:0];
                    bval_next = rd_q;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (best_reg == pos_reg)
                begin
                    mem_wd = cur_reg;
                    if (!second_reg && got_reg.sym)
                    begin
                        if (pair_reg != '0 && pair_reg != CW'(1))
                        begin
                            pair_next  = pair_reg - 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pair_next = '0;
                            if (cnt_reg != '0)
                            begin
                                second_next = 1'b1;
                                state_next  = S_TAKE_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                    end
                    else
                    begin
                        if (second_reg && got_reg.sym && pair_reg != '0)
                        begin
                            pair_next = pair_reg - 1'b1;
                        end
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    mem_wd     = bval_reg;
                    pos_next   = best_reg;
                    state_next = S_DN_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = (state_reg != S_IDLE);
        done          = (state_reg == S_DONE);
        status        = stat_reg;
        position      = rpos_reg;
        out_move      = got_reg.mv;
        out_index     = got_reg.idx;
        out_score     = got_reg.key;
        out_symmetric = got_reg.sym;
        extract_ready = !(cnt_reg == '0 || (cnt_reg == CW'(1) && pair_reg == CW'(1)));
        count         = cnt_reg;
    end

endmodule
